// ----- hw/rtl/fpba_pkg.sv -----
// fpba_pkg: shared types and constants for the fit-policy block allocator.
// No dependencies; compiled first.
package fpba_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SIZE_W    = 16;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FIRST = 2'd1,
		CMD_BEST  = 2'd2,
		CMD_WORST = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_ALLOC  = 2'd0,
		STS_NOFIT  = 2'd1,
		STS_LOADED = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	// control broadcast to every cell
	typedef struct packed {
		logic              load_en;
		logic              shift_en;
		cmd_t              cmd;
		logic [SIZE_W-1:0] size;
	} cell_ctl_t;

	// candidate carried down the chain during a scan
	typedef struct packed {
		logic              found;
		logic [SIZE_W-1:0] size;
	} rec_t;

endpackage

// ----- hw/rtl/fpba_req_if.sv -----
// fpba_req_if: request channel (command, block_size) with valid/ready.
// Depends on fpba_pkg for the field width.
interface fpba_req_if;
	import fpba_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [SIZE_W-1:0] block_size;

	modport source (output valid, output command, output block_size, input ready);
	modport sink   (input valid, input command, input block_size, output ready);

endinterface

// ----- hw/rtl/fpba_rsp_if.sv -----
// fpba_rsp_if: response channel (status, granted_size, granted_slot, blocks_left).
// Depends on fpba_pkg for the field width.
interface fpba_rsp_if;
	import fpba_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SIZE_W-1:0] granted_size;
	logic [3:0]        granted_slot;
	logic [4:0]        blocks_left;

	modport source (output valid, output status, output granted_size,
		output granted_slot, output blocks_left, input ready);
	modport sink   (input valid, input status, input granted_size,
		input granted_slot, input blocks_left, output ready);

endinterface

// ----- hw/rtl/fpba_cell.sv -----
// fpba_cell: one list slot. Holds a block size, takes part in the scan
// chain and in the shift-down after removal. Depends on fpba_pkg.
module fpba_cell #(
	parameter int SLOTS = fpba_pkg::SLOTS_DEF,
	parameter int IDX   = 0,
	parameter int IDX_W = $clog2(SLOTS),
	parameter int CNT_W = $clog2(SLOTS + 1)
) (
	input  logic                        clk,
	input  fpba_pkg::cell_ctl_t         ctl,
	input  logic [CNT_W-1:0]            count,
	input  logic [IDX_W-1:0]            pick,
	input  logic [fpba_pkg::SIZE_W-1:0] nb_size,
	input  fpba_pkg::rec_t              rec_in,
	input  logic [IDX_W-1:0]            slot_in,
	output logic [fpba_pkg::SIZE_W-1:0] size_out,
	output fpba_pkg::rec_t              rec_out,
	output logic [IDX_W-1:0]            slot_out
);
	import fpba_pkg::*;

	logic [SIZE_W-1:0] size_q;
	rec_t              rec_q;
	logic [IDX_W-1:0]  slot_q;
	logic              occupied;
	logic              fits;
	logic              take;

	assign occupied = CNT_W'(IDX) < count;
	assign fits     = occupied && (size_q >= ctl.size);

	always_comb begin
		take = 1'b0;
		if (fits) begin
			unique case (ctl.cmd)
				CMD_BEST:  take = !rec_in.found || (size_q < rec_in.size);
				CMD_WORST: take = !rec_in.found || (size_q >= rec_in.size);
				default:   take = !rec_in.found;
			endcase
		end
	end

	// slot storage: append at the tail, or close the gap left by a removal
	always_ff @(posedge clk) begin
		if (ctl.load_en && (count == CNT_W'(IDX))) begin
			size_q <= ctl.size;
		end else if (ctl.shift_en && (pick <= IDX_W'(IDX))
				&& (CNT_W'(IDX + 1) < count)) begin
			size_q <= nb_size;
		end
	end

	// scan stage, one hop per cycle
	always_ff @(posedge clk) begin
		if (take) begin
			rec_q  <= '{found: 1'b1, size: size_q};
			slot_q <= IDX_W'(IDX);
		end else begin
			rec_q  <= rec_in;
			slot_q <= slot_in;
		end
	end

	assign size_out = size_q;
	assign rec_out  = rec_q;
	assign slot_out = slot_q;

endmodule

// ----- hw/rtl/fit_policy_block_allocator.sv -----
// fit_policy_block_allocator: ordered free-block list with first/best/worst
// fit allocation, built as a chain of fpba_cell. Depends on fpba_pkg,
// fpba_req_if, fpba_rsp_if and fpba_cell.
//
//  channel | dir | payload                                           | handshake
//  --------+-----+---------------------------------------------------+----------
//  req     | in  | command[1:0], block_size[15:0]                    | valid/ready
//  rsp     | out | status[1:0], granted_size[15:0], granted_slot[3:0],| valid/ready
//          |     | blocks_left[4:0]                                  |
//
// Sequence: a load's result is pending in the cycle after its accept. An
// allocation walks the candidate down the cell chain in ST_SCAN, one cell per
// cycle, then passes ST_SHIFT, which makes its result pending. ST_RESP moves it
// into the response register once that register is free or being taken, and
// then returns to idle, ready for the next request.
// One transaction is in work at a time; req.ready is high only when idle.
// Reset (arst_n low, asynchronous) empties the list and drops any response.
// A held response does not block a new request; only a second result
// waits in the pending state until rsp is taken.
module fit_policy_block_allocator #(
	parameter int SLOTS = fpba_pkg::SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fpba_req_if.sink   req,
	fpba_rsp_if.source rsp
);
	import fpba_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_q;
	cmd_t              cmd_q;
	logic [SIZE_W-1:0] req_size_q;

	// pending result, waiting for the response register
	status_t           res_status_q;
	logic [SIZE_W-1:0] res_size_q;
	logic [IDX_W-1:0]  res_slot_q;

	// response register
	logic              out_valid_q;
	status_t           out_status_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [3:0]        out_slot_q;
	logic [4:0]        out_left_q;

	logic              accept;
	logic              is_load;
	logic              full;
	logic              done_scan;
	logic              out_load;
	cell_ctl_t         ctl;

	// chain wiring
	logic [SIZE_W-1:0] sizes [SLOTS];
	rec_t              rec   [SLOTS+1];
	logic [IDX_W-1:0]  slot  [SLOTS+1];
	logic [IDX_W-1:0]  rec_slot_pick;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_load   = (cmd_t'(req.command) == CMD_LOAD);
	assign full      = (count_q == CNT_W'(SLOTS));
	assign done_scan = (scan_q == IDX_W'(SLOTS - 1));
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	// size bus: the incoming size while idle (load), else the held request
	always_comb begin
		ctl.load_en  = accept && is_load && !full;
		ctl.shift_en = (state_q == ST_SHIFT) && rec[SLOTS].found;
		ctl.cmd      = cmd_q;
		ctl.size     = (state_q == ST_IDLE) ? req.block_size : req_size_q;
	end

	assign rec[0]  = '0;
	assign slot[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [SIZE_W-1:0] nb;
		if (i == SLOTS - 1) begin : g_tail
			assign nb = sizes[i];
		end else begin : g_mid
			assign nb = sizes[i+1];
		end

		fpba_cell #(
			.SLOTS (SLOTS),
			.IDX   (i),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count_q),
			.pick     (rec_slot_pick),
			.nb_size  (nb),
			.rec_in   (rec[i]),
			.slot_in  (slot[i]),
			.size_out (sizes[i]),
			.rec_out  (rec[i+1]),
			.slot_out (slot[i+1])
		);
	end

	assign rec_slot_pick = slot[SLOTS];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_load) begin
							if (!full) count_q <= count_q + CNT_W'(1);
							state_q <= ST_RESP;
						end else begin
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + IDX_W'(1);
					if (done_scan) state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (rec[SLOTS].found) count_q <= count_q - CNT_W'(1);
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(req.command);
			req_size_q <= req.block_size;
			res_size_q <= '0;
			res_slot_q <= '0;
			res_status_q <= full ? STS_FULL : STS_LOADED;
		end else if (state_q == ST_SHIFT) begin
			if (rec[SLOTS].found) begin
				res_status_q <= STS_ALLOC;
				res_size_q   <= rec[SLOTS].size;
				res_slot_q   <= slot[SLOTS];
			end else begin
				res_status_q <= STS_NOFIT;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_size_q   <= res_size_q;
			out_slot_q   <= 4'(res_slot_q);
			out_left_q   <= 5'(count_q);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.granted_size = out_size_q;
	assign rsp.granted_slot = out_slot_q;
	assign rsp.blocks_left  = out_left_q;

endmodule

// ----- hw/rtl/fpba_checker.sv -----
// fpba_checker: port-level checks for fit_policy_block_allocator, bound in
// below. Depends on fpba_pkg.
module fpba_checker #(
	parameter int SLOTS = fpba_pkg::SLOTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [15:0] rsp_size,
	input logic [3:0]  rsp_slot,
	input logic [4:0]  rsp_left
);
	import fpba_pkg::*;

	// one transaction in work: ready drops right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_size) && $stable(rsp_slot) && $stable(rsp_left))
		else $error("response changed while stalled");

	// only an allocation reports a size or slot
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STS_ALLOC) |-> (rsp_size == '0) && (rsp_slot == '0))
		else $error("grant fields set without allocation");

	// count stays in range, a load leaves at least one block, and FULL reports a full list
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_left) <= SLOTS)
			&& ((rsp_status != STS_LOADED) || (rsp_left != '0))
			&& ((rsp_status != STS_FULL) || (32'(rsp_left) == SLOTS)))
		else $error("blocks_left inconsistent with status");

endmodule

bind fit_policy_block_allocator fpba_checker #(.SLOTS(SLOTS)) u_fpba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_size   (rsp.granted_size),
	.rsp_slot   (rsp.granted_slot),
	.rsp_left   (rsp.blocks_left)
);

// ----- sim/tb_fit_policy_block_allocator.sv -----
// tb_fit_policy_block_allocator: self-checking testbench for the fit-policy block allocator.
// Needs fpba_pkg, fpba_req_if, fpba_rsp_if and the allocator RTL; nothing else.
`timescale 1ns / 1ps

module tb_fit_policy_block_allocator;
	import fpba_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * SLOTS_DEF + 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1625;
	localparam int MAX_PRINTED = 50;

	// One expected response, laid out like the response channel.
	typedef struct packed {
		status_t           status;
		logic [SIZE_W-1:0] granted_size;
		logic [3:0]        granted_slot;
		logic [4:0]        blocks_left;
	} alloc_result_t;

	// Shadow free list plus the queue of responses still owed by the block.
	// Requests are noted when accepted; responses are checked in order.
	class alloc_scoreboard;
		logic [SIZE_W-1:0] free_list [SLOTS_DEF];
		int unsigned       held;
		alloc_result_t     owed[$];
		int unsigned       mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		task report_mismatch(string what);
			if (mismatches < MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		function void note_request(cmd_t cmd, logic [SIZE_W-1:0] size);
			alloc_result_t r;
			int pick;
			r = '{status: STS_NOFIT, granted_size: '0, granted_slot: '0, blocks_left: '0};
			pick = -1;
			if (cmd == CMD_LOAD) begin
				if (held >= SLOTS_DEF) begin
					r.status = STS_FULL;
				end else begin
					free_list[held] = size;
					held++;
					r.status = STS_LOADED;
				end
			end else begin
				// first fit keeps the earliest candidate, best fit the strictly
				// smaller one, worst fit the larger or equal one (latest wins ties)
				for (int i = 0; i < held; i++) begin
					if (free_list[i] >= size) begin
						if (pick < 0)
							pick = i;
						else if (cmd == CMD_BEST && free_list[i] < free_list[pick])
							pick = i;
						else if (cmd == CMD_WORST && free_list[i] >= free_list[pick])
							pick = i;
					end
				end
				if (pick >= 0) begin
					r.status = STS_ALLOC;
					r.granted_size = free_list[pick];
					r.granted_slot = pick[3:0];
					for (int i = pick; i + 1 < held; i++)
						free_list[i] = free_list[i + 1];
					held--;
				end
			end
			r.blocks_left = held[4:0];
			owed.push_back(r);
		endfunction

		task check_response(logic [1:0] status, logic [SIZE_W-1:0] granted_size,
				logic [3:0] granted_slot, logic [4:0] blocks_left);
			alloc_result_t e;
			if (owed.size() == 0) begin
				report_mismatch("response with no request outstanding");
				return;
			end
			e = owed.pop_front();
			if (status !== e.status)
				report_mismatch($sformatf("status %0d, expected %s", status, e.status.name()));
			if (granted_size !== e.granted_size)
				report_mismatch($sformatf("granted_size %0h, expected %0h",
					granted_size, e.granted_size));
			if (granted_slot !== e.granted_slot)
				report_mismatch($sformatf("granted_slot %0d, expected %0d",
					granted_slot, e.granted_slot));
			if (blocks_left !== e.blocks_left)
				report_mismatch($sformatf("blocks_left %0d, expected %0d",
					blocks_left, e.blocks_left));
		endtask

		// a size on the list (small random when empty), so requests land on exact matches and ties
		function logic [SIZE_W-1:0] any_held_size();
			if (held == 0)
				return SIZE_W'($urandom_range(0, 15));
			return free_list[$urandom_range(0, held - 1)];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpba_req_if req_ch ();
	fpba_rsp_if rsp_ch ();

	alloc_scoreboard sb = new();

	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;       // both sides stop idling while set
	bit          hold_off_req = 1'b0; // asks the response side for one long stall

	fit_policy_block_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Monitor: everything is sampled on the rising edge, before the block's
	// own registers move, so a transaction is seen exactly when it happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(cmd_t'(req_ch.command), req_ch.block_size);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.status, rsp_ch.granted_size,
					rsp_ch.granted_slot, rsp_ch.blocks_left);
		end
	end

	// Response side: a random gap before each transaction, and one long
	// stall on request so the block holds a response, fills its pending
	// slot and drops req.ready while the sender keeps offering.
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			gap = quiet ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// Offer one request; called and returning on a falling edge. valid stays
	// high straight into the next request when no gap is drawn.
	task send_request(cmd_t cmd, logic [SIZE_W-1:0] size);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.command = cmd;
		req_ch.block_size = size;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Sizes: often small (lots of ties), some full range, the extremes, and
	// values at or next to a block already on the list.
	function logic [SIZE_W-1:0] pick_size();
		int near;
		case ($urandom_range(0, 5))
			0, 1: return SIZE_W'($urandom_range(0, 15));
			2: return SIZE_W'($urandom);
			3: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return 16'h8000;
					default: return 16'h7FFF;
				endcase
			end
			default: begin
				near = int'(sb.any_held_size()) + $urandom_range(0, 2) - 1;
				if (near < 0)
					near = 0;
				if (near > 65535)
					near = 65535;
				return SIZE_W'(near);
			end
		endcase
	endfunction

	initial begin
		logic [SIZE_W-1:0] load_sizes [16];
		int load_pct;
		cmd_t cmd;

		load_sizes = '{16'd5, 16'hFFFF, 16'd3, 16'd7, 16'd3, 16'hFFFF,
			16'd0, 16'd7, 16'd12, 16'd5, 16'd1, 16'd9, 16'h8000, 16'h7FFF, 16'd2, 16'h9000};
		req_ch.valid = 1'b0;
		req_ch.command = CMD_LOAD;
		req_ch.block_size = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed ---
		// allocation from an empty list, with both extreme request sizes
		send_request(CMD_FIRST, 16'h0000);
		send_request(CMD_WORST, 16'hFFFF);
		send_request(CMD_BEST, 16'h0000);
		// fill the list completely, then one load too many
		foreach (load_sizes[i])
			send_request(CMD_LOAD, load_sizes[i]);
		send_request(CMD_LOAD, 16'h1234);
		// best fit tie: the earlier of the two 3s goes
		send_request(CMD_BEST, 16'd3);
		// zero request, worst fit: the later of the two largest goes
		send_request(CMD_WORST, 16'd0);
		send_request(CMD_FIRST, 16'd100);
		// first fit whose only candidate is the last entry
		send_request(CMD_FIRST, 16'h8001);
		// nothing left that large
		send_request(CMD_FIRST, 16'hFFFF);

		// --- random ---
		// Phases of 60 transactions lean towards filling, draining or a mix,
		// so both the full and the empty list are visited repeatedly.
		load_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				case ($urandom_range(0, 2))
					0: load_pct = 15;
					1: load_pct = 50;
					default: load_pct = 85;
				endcase
				quiet = ($urandom_range(0, 4) == 0);
			end
			if (n == 600)
				hold_off_req = 1'b1;
			if ($urandom_range(1, 100) <= load_pct)
				cmd = CMD_LOAD;
			else
				cmd = cmd_t'($urandom_range(1, 3));
			send_request(cmd, pick_size());
		end
		req_ch.valid = 1'b0;
		quiet = 1'b0;

		// drain, then give the block time to show any stray response
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.owed.size() != 0)
			sb.report_mismatch("expected responses never arrived");

		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
